FILE: rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

	// Branch codes reported on branch_taken.
	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_FWD_X = 2'd1,
		BR_RGT_Y = 2'd2,
		BR_UP_Z  = 2'd3
	} branch_t;

	// Control that travels with a transaction through the pipeline.
	typedef struct packed {
		logic    vld;
		branch_t br;
		logic    degen;
	} ctl_t;

endpackage

FILE: rtl/rmq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
	parameter int IN_W = 32
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IN_W-1:0]     rad,
	output logic [IN_W/2-1:0]   root
);
	localparam int RW = IN_W / 2;

	logic [IN_W-1:0] rem_s [RW+1];
	logic [RW-1:0]   res_s [RW+1];
	logic [IN_W-1:0] rad_s [RW+1];

	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign rad_s[0] = rad;

	// Each stage brings down two radicand bits and decides one root bit.
	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [IN_W+1:0] trial;
		logic [IN_W+1:0] cand;
		assign cand  = {rem_s[i], rad_s[i][IN_W-1 -: 2]};
		assign trial = cand - {res_s[i], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[IN_W+1]) begin
					rem_s[i+1] <= trial[IN_W-1:0];
					res_s[i+1] <= {res_s[i][RW-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= cand[IN_W-1:0];
					res_s[i+1] <= {res_s[i][RW-2:0], 1'b0};
				end
				rad_s[i+1] <= {rad_s[i][IN_W-3:0], 2'b00};
			end
		end
	end

	assign root = res_s[RW];
endmodule

FILE: rtl/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined signed restoring divider, one quotient bit per stage; truncates
// toward zero.
// ----------------------------------------------------------------------------
module rmq_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] mag,
	input  logic             neg,
	input  logic [DEN_W-1:0] den,
	output logic signed [NUM_W:0] quo
);
	logic [DEN_W-1:0] rem_s [NUM_W+1];
	logic [NUM_W-1:0] q_s   [NUM_W+1];
	logic [DEN_W-1:0] den_s [NUM_W+1];
	logic             neg_s [NUM_W+1];

	assign rem_s[0] = '0;
	assign q_s[0]   = mag;
	assign den_s[0] = den;
	assign neg_s[0] = neg;

	// The dividend shifts out of q while quotient bits shift in.
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] cand;
		logic [DEN_W:0] diff;
		assign cand = {rem_s[i], q_s[i][NUM_W-1]};
		assign diff = cand - {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (cand >= {1'b0, den_s[i]}) begin
					rem_s[i+1] <= diff[DEN_W-1:0];
					q_s[i+1]   <= {q_s[i][NUM_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= cand[DEN_W-1:0];
					q_s[i+1]   <= {q_s[i][NUM_W-2:0], 1'b0};
				end
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign quo = neg_s[NUM_W] ? -$signed({1'b0, q_s[NUM_W]})
	                          :  $signed({1'b0, q_s[NUM_W]});
endmodule

FILE: rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to a quaternion.
// ----------------------------------------------------------------------------
// The block takes one matrix per cycle while the result side does not stall,
// and returns one quaternion per matrix in order. A matrix passes stage 1,
// stage 2, the square root pipeline, the stage after the root, the divider
// pipeline and the output register: the square root pipeline resolves one root
// bit per stage and the divider pipeline one quotient bit per stage. The whole
// pipeline advances when the output register is empty or being taken, so stall
// on the result side holds every stage and is passed back on the input stall.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS  = 14,
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] fwd_x,
	input  logic signed [DATA_WIDTH-1:0] fwd_y,
	input  logic signed [DATA_WIDTH-1:0] fwd_z,
	input  logic signed [DATA_WIDTH-1:0] rgt_x,
	input  logic signed [DATA_WIDTH-1:0] rgt_y,
	input  logic signed [DATA_WIDTH-1:0] rgt_z,
	input  logic signed [DATA_WIDTH-1:0] up_x,
	input  logic signed [DATA_WIDTH-1:0] up_y,
	input  logic signed [DATA_WIDTH-1:0] up_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] quat_w,
	output logic signed [DATA_WIDTH-1:0] quat_x,
	output logic signed [DATA_WIDTH-1:0] quat_y,
	output logic signed [DATA_WIDTH-1:0] quat_z,
	output logic [1:0]                   branch_taken,
	output logic                         degenerate
);
	localparam int AW    = DATA_WIDTH + 3;            // root argument width
	localparam int SQ_W  = 2 * (((AW + FRAC_BITS) + 1) / 2);
	localparam int RT_W  = SQ_W / 2;
	localparam int NW    = DATA_WIDTH + 1;            // numerator width
	localparam int DV_W  = NW + FRAC_BITS;            // dividend magnitude
	localparam int DEN_W = RT_W + 1;
	localparam int SQ_LAT = RT_W;
	localparam int DV_LAT = DV_W;
	localparam int DLY   = SQ_LAT + 1 + DV_LAT;       // after stage 2
	localparam logic signed [AW-1:0] ONE = AW'(1) <<< FRAC_BITS;
	localparam logic signed [DV_W:0] SMAX = (DV_W+1)'((1 << (DATA_WIDTH-1)) - 1);
	localparam logic signed [DV_W:0] SMIN = -SMAX - 1;

	logic en;
	rmq_pkg::ctl_t out_q;

	// The pipeline moves when the output register can take a new value.
	assign en       = !out_q.vld || !out_stall;
	assign in_stall = !en;

	// Stage 1: trace, branch choice and numerators.
	rmq_pkg::ctl_t ctl_s1;
	logic signed [AW-1:0] arg_s1;
	logic signed [NW-1:0] n0_s1, n1_s1, n2_s1;
	logic signed [AW-1:0] tr, a1, a2, a3;
	logic signed [AW-1:0] fx, ry, uz;
	assign fx = AW'(fwd_x);
	assign ry = AW'(rgt_y);
	assign uz = AW'(up_z);
	assign tr = fx + ry + uz;
	assign a1 = ONE + fx - ry - uz;
	assign a2 = ONE + ry - fx - uz;
	assign a3 = ONE + uz - fx - ry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			arg_s1 <= '0;
			n0_s1  <= '0;
			n1_s1  <= '0;
			n2_s1  <= '0;
		end else if (en) begin
			ctl_s1.vld   <= in_valid;
			ctl_s1.degen <= 1'b0;
			if (tr > 0) begin
				ctl_s1.br <= rmq_pkg::BR_TRACE;
				arg_s1    <= tr + ONE;
				n0_s1 <= NW'(rgt_z) - NW'(up_y);
				n1_s1 <= NW'(up_x) - NW'(fwd_z);
				n2_s1 <= NW'(fwd_y) - NW'(rgt_x);
			end else if (fx > ry && fx > uz) begin
				ctl_s1.br <= rmq_pkg::BR_FWD_X;
				arg_s1    <= a1;
				n0_s1 <= NW'(rgt_z) - NW'(up_y);
				n1_s1 <= NW'(rgt_x) + NW'(fwd_y);
				n2_s1 <= NW'(up_x) + NW'(fwd_z);
			end else if (ry > uz) begin
				ctl_s1.br <= rmq_pkg::BR_RGT_Y;
				arg_s1    <= a2;
				n0_s1 <= NW'(up_x) - NW'(fwd_z);
				n1_s1 <= NW'(rgt_x) + NW'(fwd_y);
				n2_s1 <= NW'(up_y) + NW'(rgt_z);
			end else begin
				ctl_s1.br <= rmq_pkg::BR_UP_Z;
				arg_s1    <= a3;
				n0_s1 <= NW'(fwd_y) - NW'(rgt_x);
				n1_s1 <= NW'(up_x) + NW'(fwd_z);
				n2_s1 <= NW'(up_y) + NW'(rgt_z);
			end
		end
	end

	// Stage 2: degeneracy check and radicand for the root.
	rmq_pkg::ctl_t ctl_s2;
	logic [SQ_W-1:0] rad_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			rad_s2 <= '0;
		end else if (en) begin
			ctl_s2.vld   <= ctl_s1.vld;
			ctl_s2.br    <= ctl_s1.br;
			ctl_s2.degen <= (arg_s1 <= 0);
			rad_s2 <= (arg_s1 <= 0) ? '0
			        : SQ_W'({arg_s1[AW-2:0], {FRAC_BITS{1'b0}}});
		end
	end

	// Control waits beside the root and divider pipelines, numerators beside the root.
	rmq_pkg::ctl_t ctl_d [DLY+1];
	logic signed [NW-1:0] n0_d [SQ_LAT+1];
	logic signed [NW-1:0] n1_d [SQ_LAT+1];
	logic signed [NW-1:0] n2_d [SQ_LAT+1];
	assign ctl_d[0] = ctl_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			n0_d[0] <= n0_s1;
			n1_d[0] <= n1_s1;
			n2_d[0] <= n2_s1;
		end
	end
	for (genvar i = 0; i < DLY; i++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_d[i+1] <= '0;
			end else if (en) begin
				ctl_d[i+1] <= ctl_d[i];
			end
		end
	end
	for (genvar i = 0; i < SQ_LAT; i++) begin : g_num
		always_ff @(posedge clk) begin
			if (en) begin
				n0_d[i+1] <= n0_d[i];
				n1_d[i+1] <= n1_d[i];
				n2_d[i+1] <= n2_d[i];
			end
		end
	end

	// Square root.
	logic [RT_W-1:0] root;
	rmq_sqrt #(.IN_W(SQ_W)) u_sqrt (
		.clk(clk), .en(en), .rad(rad_s2), .root(root)
	);

	// Stage after the root: magnitudes, signs and divisor.
	logic [DV_W-1:0]  m0_s3, m1_s3, m2_s3;
	logic             g0_s3, g1_s3, g2_s3;
	logic [DEN_W-1:0] den_s3;
	logic [RT_W-1:0]  half_s3;
	logic [NW-1:0]    ab0, ab1, ab2;
	assign ab0 = n0_d[SQ_LAT][NW-1] ? NW'(-n0_d[SQ_LAT]) : NW'(n0_d[SQ_LAT]);
	assign ab1 = n1_d[SQ_LAT][NW-1] ? NW'(-n1_d[SQ_LAT]) : NW'(n1_d[SQ_LAT]);
	assign ab2 = n2_d[SQ_LAT][NW-1] ? NW'(-n2_d[SQ_LAT]) : NW'(n2_d[SQ_LAT]);
	always_ff @(posedge clk) begin
		if (en) begin
			m0_s3 <= {ab0, {FRAC_BITS{1'b0}}};
			m1_s3 <= {ab1, {FRAC_BITS{1'b0}}};
			m2_s3 <= {ab2, {FRAC_BITS{1'b0}}};
			g0_s3 <= n0_d[SQ_LAT][NW-1];
			g1_s3 <= n1_d[SQ_LAT][NW-1];
			g2_s3 <= n2_d[SQ_LAT][NW-1];
			den_s3  <= (root == '0) ? DEN_W'(1) : {root, 1'b0};
			half_s3 <= root >> 1;
		end
	end

	// Three dividers, one per non-root component.
	logic signed [DV_W:0] q0, q1, q2;
	rmq_div #(.NUM_W(DV_W), .DEN_W(DEN_W)) u_div0 (
		.clk(clk), .en(en), .mag(m0_s3), .neg(g0_s3), .den(den_s3), .quo(q0)
	);
	rmq_div #(.NUM_W(DV_W), .DEN_W(DEN_W)) u_div1 (
		.clk(clk), .en(en), .mag(m1_s3), .neg(g1_s3), .den(den_s3), .quo(q1)
	);
	rmq_div #(.NUM_W(DV_W), .DEN_W(DEN_W)) u_div2 (
		.clk(clk), .en(en), .mag(m2_s3), .neg(g2_s3), .den(den_s3), .quo(q2)
	);

	// The half root travels beside the dividers.
	logic [RT_W-1:0] half_d [DV_LAT+1];
	logic            zr_d   [DV_LAT+1];
	assign half_d[0] = half_s3;
	assign zr_d[0]   = (den_s3 == DEN_W'(1));
	for (genvar i = 0; i < DV_LAT; i++) begin : g_half
		always_ff @(posedge clk) begin
			if (en) begin
				half_d[i+1] <= half_d[i];
				zr_d[i+1]   <= zr_d[i];
			end
		end
	end

	function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [DV_W:0] v);
		logic signed [DATA_WIDTH-1:0] r;
		if (v > SMAX) r = SMAX[DATA_WIDTH-1:0];
		else if (v < SMIN) r = SMIN[DATA_WIDTH-1:0];
		else r = v[DATA_WIDTH-1:0];
		return r;
	endfunction

	// Output assembly: place the half root and quotients by branch.
	rmq_pkg::ctl_t ctl_f;
	logic signed [DV_W:0] hv;
	logic signed [DATA_WIDTH-1:0] w_n, x_n, y_n, z_n;
	logic dg;
	assign ctl_f = ctl_d[DLY];
	assign hv = (DV_W+1)'(half_d[DV_LAT]);
	assign dg = ctl_f.degen || zr_d[DV_LAT];
	always_comb begin
		w_n = sat(q0); x_n = sat(q1); y_n = sat(q2); z_n = sat(q2);
		case (ctl_f.br)
			rmq_pkg::BR_TRACE: begin
				w_n = sat(hv); x_n = sat(q0); y_n = sat(q1); z_n = sat(q2);
			end
			rmq_pkg::BR_FWD_X: begin
				w_n = sat(q0); x_n = sat(hv); y_n = sat(q1); z_n = sat(q2);
			end
			rmq_pkg::BR_RGT_Y: begin
				w_n = sat(q0); x_n = sat(q1); y_n = sat(hv); z_n = sat(q2);
			end
			rmq_pkg::BR_UP_Z: begin
				w_n = sat(q0); x_n = sat(q1); y_n = sat(q2); z_n = sat(hv);
			end
			default: begin
				w_n = '0; x_n = '0; y_n = '0; z_n = '0;
			end
		endcase
		if (dg) begin
			w_n = '0; x_n = '0; y_n = '0; z_n = '0;
		end
	end

	logic signed [DATA_WIDTH-1:0] w_q, x_q, y_q, z_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (en) begin
			out_q.vld   <= ctl_f.vld;
			out_q.br    <= ctl_f.br;
			out_q.degen <= dg;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_q <= w_n; x_q <= x_n; y_q <= y_n; z_q <= z_n;
		end
	end

	assign out_valid    = out_q.vld;
	assign quat_w       = w_q;
	assign quat_x       = x_q;
	assign quat_y       = y_q;
	assign quat_z       = z_q;
	assign branch_taken = out_q.br;
	assign degenerate   = out_q.degen;

	// A degenerate result carries a zero quaternion.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0)
		else $error("degenerate result with nonzero quaternion");
	// The trace branch is never degenerate.
	a_trace_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken == rmq_pkg::BR_TRACE |-> !degenerate)
		else $error("trace branch flagged degenerate");
	// Input stall follows a held, full output register.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
endmodule

FILE: sim/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Self-checking bench for the matrix to quaternion converter.
// ----------------------------------------------------------------------------
// A directed table covers the identity, the three half-turn rotations, ties on
// the diagonal, large opposing diagonal entries and full-scale entries. Random
// matrices follow, most of them close to real rotations and the rest raw
// noise. Rows with a typed-in result use it; every other transaction is predicted
// by an integer model of the conversion, and each result is compared field by
// field with the oldest prediction. Both sides wait a random number of cycles between transactions.
module rotation_matrix_to_quaternion_test;

	localparam int FRAC = 14;
	localparam int DW   = 16;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam longint SMAX = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;
	localparam int NUM_RANDOM = 1030;
	localparam int DRAIN_CYCLES = 80;

	typedef logic signed [DW-1:0] fx_t;

	typedef struct {
		fx_t m[9];
	} matrix_t;

	typedef struct {
		fx_t              w, x, y, z;
		rmq_pkg::branch_t br;
		logic             degen;
	} quat_t;

	// Directed row: a matrix, and optionally a typed-in expected result.
	typedef struct {
		matrix_t mat;
		bit      has_exp;
		quat_t   exp;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	fx_t  fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z, up_x, up_y, up_z;
	logic out_valid;
	logic out_stall;
	fx_t  quat_w, quat_x, quat_y, quat_z;
	logic [1:0] branch_taken;
	logic degenerate;

	quat_t pending_quats[$];
	int    error_count;
	bit    stimulus_done;

	rotation_matrix_to_quaternion #(
		.FRAC_BITS(FRAC),
		.DATA_WIDTH(DW)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
		.rgt_x(rgt_x), .rgt_y(rgt_y), .rgt_z(rgt_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.branch_taken(branch_taken), .degenerate(degenerate)
	);

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint clamp(longint v);
		if (v > SMAX)
			return SMAX;
		if (v < SMIN)
			return SMIN;
		return v;
	endfunction

	// Integer square root by bisection on the result.
	function automatic longint root_floor(longint n);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'd3037000499;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Fixed-point quotient num / den, truncated toward zero.
	function automatic longint fixed_quot(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag <<< FRAC) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic quat_t convert(matrix_t mt);
		quat_t  q;
		longint fx, fy, fz, rx, ry, rz, ux, uy, uz, tr, arg, r, den, half;
		longint w, x, y, z;
		fx = mt.m[0]; fy = mt.m[1]; fz = mt.m[2];
		rx = mt.m[3]; ry = mt.m[4]; rz = mt.m[5];
		ux = mt.m[6]; uy = mt.m[7]; uz = mt.m[8];
		tr = fx + ry + uz;
		w = 0; x = 0; y = 0; z = 0;
		q.degen = 1'b0;
		if (tr > 0) begin
			q.br = rmq_pkg::BR_TRACE;
			arg = tr + ONE;
		end else if (fx > ry && fx > uz) begin
			q.br = rmq_pkg::BR_FWD_X;
			arg = ONE + fx - ry - uz;
		end else if (ry > uz) begin
			q.br = rmq_pkg::BR_RGT_Y;
			arg = ONE + ry - fx - uz;
		end else begin
			q.br = rmq_pkg::BR_UP_Z;
			arg = ONE + uz - fx - ry;
		end
		if (arg <= 0) begin
			q.degen = 1'b1;
		end else begin
			r = root_floor(arg <<< FRAC);
			den = 2 * r;
			half = r >>> 1;
			if (den == 0) begin
				q.degen = 1'b1;
			end else begin
				case (q.br)
					rmq_pkg::BR_TRACE: begin
						w = half;
						x = fixed_quot(rz - uy, den);
						y = fixed_quot(ux - fz, den);
						z = fixed_quot(fy - rx, den);
					end
					rmq_pkg::BR_FWD_X: begin
						w = fixed_quot(rz - uy, den);
						x = half;
						y = fixed_quot(rx + fy, den);
						z = fixed_quot(ux + fz, den);
					end
					rmq_pkg::BR_RGT_Y: begin
						w = fixed_quot(ux - fz, den);
						x = fixed_quot(rx + fy, den);
						y = half;
						z = fixed_quot(uy + rz, den);
					end
					default: begin
						w = fixed_quot(fy - rx, den);
						x = fixed_quot(ux + fz, den);
						y = fixed_quot(uy + rz, den);
						z = half;
					end
				endcase
			end
		end
		if (q.degen) begin
			w = 0; x = 0; y = 0; z = 0;
		end
		q.w = fx_t'(clamp(w));
		q.x = fx_t'(clamp(x));
		q.y = fx_t'(clamp(y));
		q.z = fx_t'(clamp(z));
		return q;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic matrix_t make_matrix(int a0, int a1, int a2, int a3, int a4,
			int a5, int a6, int a7, int a8);
		matrix_t mt;
		mt.m = '{fx_t'(a0), fx_t'(a1), fx_t'(a2), fx_t'(a3), fx_t'(a4),
			fx_t'(a5), fx_t'(a6), fx_t'(a7), fx_t'(a8)};
		return mt;
	endfunction

	function automatic row_t plain_row(matrix_t mt);
		row_t rw;
		rw.mat = mt;
		rw.has_exp = 1'b0;
		rw.exp = convert(mt);
		return rw;
	endfunction

	function automatic row_t fixed_row(matrix_t mt, int w, int x, int y, int z,
			rmq_pkg::branch_t br, logic dg);
		row_t rw;
		rw.mat = mt;
		rw.has_exp = 1'b1;
		rw.exp.w = fx_t'(w);
		rw.exp.x = fx_t'(x);
		rw.exp.y = fx_t'(y);
		rw.exp.z = fx_t'(z);
		rw.exp.br = br;
		rw.exp.degen = dg;
		return rw;
	endfunction

	// Entry near a real rotation: a small set of typical values plus jitter.
	function automatic fx_t near_unit();
		int base;
		case ($urandom_range(0, 4))
			0: base = 0;
			1: base = 16384;
			2: base = -16384;
			3: base = 11585;
			default: base = -11585;
		endcase
		return fx_t'(base + $signed($urandom_range(0, 2000)) - 1000);
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t mt;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			if (kind < 7)
				mt.m[i] = near_unit();
			else
				mt.m[i] = fx_t'($urandom);
		end
		return mt;
	endfunction

	// Valid drops only while idling, so it never gets two updates in one step.
	task automatic send_matrix(matrix_t mt);
		int idle;
		idle = $urandom_range(0, 16);
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		{fwd_x, fwd_y, fwd_z} <= {mt.m[0], mt.m[1], mt.m[2]};
		{rgt_x, rgt_y, rgt_z} <= {mt.m[3], mt.m[4], mt.m[5]};
		{up_x, up_y, up_z} <= {mt.m[6], mt.m[7], mt.m[8]};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stimulus.
	initial begin
		row_t rows[$];
		in_valid = 1'b0;
		{fwd_x, fwd_y, fwd_z, rgt_x, rgt_y, rgt_z, up_x, up_y, up_z} = '0;
		stimulus_done = 1'b0;
		error_count = 0;

		// Identity and the half turns about each axis.
		rows.push_back(fixed_row(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
			16384, 0, 0, 0, rmq_pkg::BR_TRACE, 1'b0));
		rows.push_back(fixed_row(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384),
			0, 16384, 0, 0, rmq_pkg::BR_FWD_X, 1'b0));
		rows.push_back(fixed_row(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384),
			0, 0, 16384, 0, rmq_pkg::BR_RGT_Y, 1'b0));
		rows.push_back(fixed_row(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384),
			0, 0, 0, 16384, rmq_pkg::BR_UP_Z, 1'b0));
		// All zero: trace zero, ties fall through to the up branch.
		rows.push_back(fixed_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 8192, rmq_pkg::BR_UP_Z, 1'b0));
		// Large opposing diagonal entries in each non-trace branch.
		rows.push_back(plain_row(make_matrix(-100, 0, 0, 0, 32767, 0, 0, 0, -32768)));
		rows.push_back(plain_row(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768)));
		rows.push_back(plain_row(make_matrix(0, 0, 0, 0, -32768, 0, 0, 0, -32768)));
		// Ties on the diagonal with negative trace.
		rows.push_back(plain_row(make_matrix(-5000, 7, 9, 11, -5000, 3, 1, 2, -6000)));
		rows.push_back(plain_row(make_matrix(-5000, 7, 9, 11, -6000, 3, 1, 2, -5000)));
		rows.push_back(plain_row(make_matrix(-4000, 7, 9, 11, -4000, 3, 1, 2, -4000)));
		// Full scale entries.
		rows.push_back(plain_row(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767)));
		rows.push_back(plain_row(make_matrix(-32768, -32768, -32768, -32768, 32767,
			-32768, -32768, -32768, -32768)));
		rows.push_back(plain_row(make_matrix(-16384, 32767, -32768, -32768, -16384,
			32767, 32767, -32768, -16384)));
		rows.push_back(plain_row(make_matrix(1, -32768, 32767, 32767, 0, -32768,
			-32768, 32767, 0)));
		// Small trace and a 90 degree turn about Z.
		rows.push_back(plain_row(make_matrix(1, 0, 0, 0, 0, 0, 0, 0, 0)));
		rows.push_back(plain_row(make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384)));
		rows.push_back(plain_row(make_matrix(-21, -1, 0, 5, 10, 0, -3, 0, 10)));

		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].has_exp)
				pending_quats.push_back(rows[i].exp);
			else
				pending_quats.push_back(convert(rows[i].mat));
			send_matrix(rows[i].mat);
		end
		for (int i = 0; i < NUM_RANDOM; i++) begin
			matrix_t mt;
			mt = random_matrix();
			pending_quats.push_back(convert(mt));
			send_matrix(mt);
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Result side stall: a random wait before each transaction is taken.
	initial begin
		int hold;
		out_stall = 1'b1;
		forever begin
			hold = $urandom_range(0, 16);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Result checking.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_quats.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				quat_t e;
				e = pending_quats.pop_front();
				if (quat_w !== e.w)
					report_mismatch("quat_w", quat_w, e.w);
				if (quat_x !== e.x)
					report_mismatch("quat_x", quat_x, e.x);
				if (quat_y !== e.y)
					report_mismatch("quat_y", quat_y, e.y);
				if (quat_z !== e.z)
					report_mismatch("quat_z", quat_z, e.z);
				if (branch_taken !== e.br)
					report_mismatch("branch_taken", branch_taken, e.br);
				if (degenerate !== e.degen)
					report_mismatch("degenerate", degenerate, e.degen);
			end
		end
	end

	// End of run.
	initial begin
		@(posedge clk);
		while (!stimulus_done || pending_quats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_quats.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
